>>> hw/rtl/wirs_pkg.sv
// Shared types and codes for the weighted roulette selector.
// Used by weighted_index_roulette_select_core; no dependencies.
`timescale 1ns / 1ps

package wirs_pkg;

    // request kinds carried in s_tuser
    localparam logic [2:0] REQ_SET_WEIGHT = 3'd0;
    localparam logic [2:0] REQ_REMOVE     = 3'd1;
    localparam logic [2:0] REQ_CLEAR      = 3'd2;
    localparam logic [2:0] REQ_CHOOSE     = 3'd3;
    localparam logic [2:0] REQ_INV_CHOOSE = 3'd4;

    // configuration register indexes
    localparam logic REG_ENTRIES_IN_USE = 1'b0;
    localparam logic REG_INITIAL_WEIGHT = 1'b1;

    localparam int TOTAL_W = 48;
    localparam int WEIGHT_W = 32;
    localparam int ACC_W = 64;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_RMW_RD,
        S_RMW_WR,
        S_CLEAR,
        S_RAISE_RD,
        S_RAISE_WR,
        S_CHECK,
        S_Q_RD,
        S_Q_LD,
        S_Q_DIV,
        S_Q_USE,
        S_SCALE_LO,
        S_SCALE_HI,
        S_SCALE_SUM,
        S_WALK_RD,
        S_WALK_CMP,
        S_DONE
    } state_t;

endpackage

>>> hw/rtl/wirs_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wirs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/weighted_index_roulette_select_core.sv
// Weighted roulette selector: one request in, one result out per request.
// The weight table lives in a wirs_ram instance; depends on wirs_pkg.
//
// Every request gives exactly one result transfer. After reset an init pass
// writes 1.0 to every entry; no request is taken meanwhile. A choice first
// raises the n entries in use when the lower bound calls for it (one RAM read
// and one write back per entry). A proportional choice then scales the total
// by the random fraction and walks the entries, one read and compare each. An
// inverse choice makes two passes, each computing total/weight per entry in a
// 1-bit per cycle divider. A new request is taken while the previous result
// still waits on m_tready.
`timescale 1ns / 1ps

module weighted_index_roulette_select_core #(
    parameter int ENTRIES = 256,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // entry_index, new_weight, random_fraction
    input  logic [2:0]  s_tuser,  // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // chosen_index
    output logic        m_tuser,  // is_choice
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    import wirs_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic signed [WEIGHT_W-1:0] FIX_ONE = WEIGHT_W'(1 << WEIGHT_FRAC_BITS);
    localparam logic signed [TOTAL_W-1:0] RESET_TOTAL =
        TOTAL_W'(((ENTRIES < 256) ? ENTRIES : 256) * (1 << WEIGHT_FRAC_BITS));
    localparam int INIT_SHIFT = TOTAL_W - WEIGHT_FRAC_BITS;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [2:0] kind_reg, kind_next;
    logic [7:0] eidx_reg, eidx_next;
    logic signed [WEIGHT_W-1:0] nw_reg, nw_next;
    logic [31:0] frac_reg, frac_next;
    logic signed [TOTAL_W-1:0] total_reg, total_next;
    logic signed [WEIGHT_W-1:0] bound_reg, bound_next;
    logic [8:0] eiu_reg, eiu_next;
    logic signed [WEIGHT_W-1:0] initw_reg, initw_next;
    logic signed [33:0] delta_reg, delta_next;
    logic signed [ACC_W-1:0] scale_val_reg, scale_val_next;
    logic [63:0] prod_lo_reg, prod_lo_next;
    logic [63:0] prod_hi_reg, prod_hi_next;
    logic signed [ACC_W-1:0] target_reg, target_next;
    logic signed [ACC_W-1:0] sum_reg, sum_next;
    logic [31:0] div_d_reg, div_d_next;
    logic [32:0] rem_reg, rem_next;
    logic [TOTAL_W-1:0] shreg_reg, shreg_next;
    logic [TOTAL_W-1:0] quo_reg, quo_next;
    logic [5:0] dcnt_reg, dcnt_next;
    logic walk_phase_reg, walk_phase_next;
    logic [7:0] res_idx_reg, res_idx_next;
    logic res_choice_reg, res_choice_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic m_tuser_reg, m_tuser_next;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [WEIGHT_W-1:0] ram_wdata, ram_rdata;

    logic [CNT_W-1:0] n_act;
    logic signed [WEIGHT_W-1:0] rd_w;
    logic signed [34:0] raise_sum, raise_nw;
    logic [TOTAL_W-1:0] t_mag;
    logic [32:0] rem_sh;
    logic div_ge;
    logic signed [ACC_W-1:0] q_val;
    logic [63:0] scale_mag, scale_r;
    logic [31:0] mul_a;
    logic [63:0] mul_p;
    logic entry_ok;
    logic [CNT_W-1:0] idx_inc;
    logic out_free;

    wirs_ram #(.WIDTH(WEIGHT_W), .DEPTH(ENTRIES)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign n_act = ({23'd0, eiu_reg} > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(eiu_reg);
    assign rd_w = ram_rdata;
    assign raise_sum = 35'(rd_w) + 35'(delta_reg);
    assign raise_nw = (raise_sum > 35'sd2147483647) ? 35'sd2147483647 : raise_sum;
    assign t_mag = total_reg[TOTAL_W-1] ? TOTAL_W'(-total_reg) : TOTAL_W'(total_reg);
    assign rem_sh = {rem_reg[31:0], shreg_reg[TOTAL_W-1]};
    assign div_ge = rem_sh >= {1'b0, div_d_reg};
    assign q_val = total_reg[TOTAL_W-1] ? -ACC_W'(quo_reg) : ACC_W'(quo_reg);
    assign scale_mag = scale_val_reg[ACC_W-1] ? 64'(-scale_val_reg) : 64'(scale_val_reg);
    assign mul_a = (state_reg == S_SCALE_LO) ? scale_mag[31:0] : scale_mag[63:32];
    assign mul_p = 64'(mul_a) * 64'(frac_reg);
    assign scale_r = prod_hi_reg + {32'd0, prod_lo_reg[63:32]};
    assign entry_ok = {24'd0, eidx_reg} < ENTRIES;
    assign idx_inc = idx_reg + CNT_W'(1);
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        kind_next = kind_reg;
        eidx_next = eidx_reg;
        nw_next = nw_reg;
        frac_next = frac_reg;
        total_next = total_reg;
        bound_next = bound_reg;
        eiu_next = eiu_reg;
        initw_next = initw_reg;
        delta_next = delta_reg;
        scale_val_next = scale_val_reg;
        prod_lo_next = prod_lo_reg;
        prod_hi_next = prod_hi_reg;
        target_next = target_reg;
        sum_next = sum_reg;
        div_d_next = div_d_reg;
        rem_next = rem_reg;
        shreg_next = shreg_reg;
        quo_next = quo_reg;
        dcnt_next = dcnt_reg;
        walk_phase_next = walk_phase_reg;
        res_idx_next = res_idx_reg;
        res_choice_next = res_choice_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;
        ram_we = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = initw_reg;
        ram_raddr = idx_reg[AW-1:0];

        if (cfg_we) begin
            unique case (cfg_index)
                REG_ENTRIES_IN_USE: eiu_next = cfg_data[8:0];
                REG_INITIAL_WEIGHT: initw_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_INIT: begin
                ram_we = 1'b1;
                ram_wdata = FIX_ONE;
                idx_next = idx_inc;
                if (idx_reg == CNT_W'(ENTRIES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next = s_tuser;
                    eidx_next = s_tdata[7:0];
                    nw_next = s_tdata[39:8];
                    frac_next = s_tdata[71:40];
                    res_idx_next = '0;
                    res_choice_next = 1'b0;
                    idx_next = '0;
                    case (s_tuser)
                        REQ_SET_WEIGHT, REQ_REMOVE: state_next = S_RMW_RD;
                        REQ_CLEAR: begin
                            total_next = '0;
                            state_next = S_CLEAR;
                        end
                        REQ_CHOOSE: begin
                            res_choice_next = 1'b1;
                            delta_next = -34'(bound_reg);
                            if (bound_reg < 0) begin
                                bound_next = '0;
                                state_next = (n_act != '0) ? S_RAISE_RD : S_CHECK;
                            end else begin
                                state_next = S_CHECK;
                            end
                        end
                        REQ_INV_CHOOSE: begin
                            res_choice_next = 1'b1;
                            delta_next = 34'(FIX_ONE) - 34'(bound_reg);
                            if (bound_reg < FIX_ONE) begin
                                bound_next = FIX_ONE;
                                state_next = (n_act != '0) ? S_RAISE_RD : S_CHECK;
                            end else begin
                                state_next = S_CHECK;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_RMW_RD: begin
                ram_raddr = AW'(eidx_reg);
                state_next = entry_ok ? S_RMW_WR : S_DONE;
            end
            S_RMW_WR: begin
                ram_we = 1'b1;
                ram_waddr = AW'(eidx_reg);
                if (kind_reg == REQ_SET_WEIGHT) begin
                    ram_wdata = nw_reg;
                    total_next = total_reg - TOTAL_W'(rd_w) + TOTAL_W'(nw_reg);
                    if (nw_reg < bound_reg) begin
                        bound_next = nw_reg;
                    end
                end else begin
                    ram_wdata = '0;
                    total_next = total_reg - TOTAL_W'(rd_w);
                    if (bound_reg > 0) begin
                        bound_next = '0;
                    end
                end
                state_next = S_DONE;
            end
            S_CLEAR: begin
                ram_we = 1'b1;
                if (idx_reg < n_act) begin
                    total_next = total_reg + TOTAL_W'(initw_reg);
                end
                idx_next = idx_inc;
                if (idx_reg == CNT_W'(ENTRIES - 1)) begin
                    bound_next = initw_reg;
                    state_next = S_DONE;
                end
            end
            S_RAISE_RD: state_next = S_RAISE_WR;
            S_RAISE_WR: begin
                ram_we = 1'b1;
                ram_wdata = raise_nw[31:0];
                total_next = total_reg + TOTAL_W'(raise_nw - 35'(rd_w));
                idx_next = idx_inc;
                state_next = (idx_inc == n_act) ? S_CHECK : S_RAISE_RD;
            end
            S_CHECK: begin
                idx_next = '0;
                if (n_act == '0) begin
                    state_next = S_DONE;
                end else if (kind_reg == REQ_CHOOSE) begin
                    scale_val_next = ACC_W'(total_reg);
                    state_next = S_SCALE_LO;
                end else begin
                    sum_next = '0;
                    walk_phase_next = 1'b0;
                    state_next = S_Q_RD;
                end
            end
            S_Q_RD: state_next = S_Q_LD;
            S_Q_LD: begin
                div_d_next = (rd_w < FIX_ONE) ? 32'(FIX_ONE) : 32'(rd_w);
                rem_next = 33'(t_mag >> INIT_SHIFT);
                shreg_next = t_mag << WEIGHT_FRAC_BITS;
                quo_next = '0;
                dcnt_next = '0;
                state_next = S_Q_DIV;
            end
            S_Q_DIV: begin
                rem_next = div_ge ? (rem_sh - {1'b0, div_d_reg}) : rem_sh;
                shreg_next = {shreg_reg[TOTAL_W-2:0], 1'b0};
                quo_next = {quo_reg[TOTAL_W-2:0], div_ge};
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'(TOTAL_W - 1)) begin
                    state_next = S_Q_USE;
                end
            end
            S_Q_USE: begin
                idx_next = idx_inc;
                if (!walk_phase_reg) begin
                    sum_next = sum_reg + q_val;
                    if (idx_inc == n_act) begin
                        scale_val_next = sum_reg + q_val;
                        state_next = S_SCALE_LO;
                    end else begin
                        state_next = S_Q_RD;
                    end
                end else if (target_reg <= q_val) begin
                    res_idx_next = 8'(idx_reg);
                    state_next = S_DONE;
                end else begin
                    target_next = target_reg - q_val;
                    if (idx_inc == n_act) begin
                        res_idx_next = 8'(idx_reg);
                        state_next = S_DONE;
                    end else begin
                        state_next = S_Q_RD;
                    end
                end
            end
            S_SCALE_LO: begin
                prod_lo_next = mul_p;
                state_next = S_SCALE_HI;
            end
            S_SCALE_HI: begin
                prod_hi_next = mul_p;
                state_next = S_SCALE_SUM;
            end
            S_SCALE_SUM: begin
                target_next = scale_val_reg[ACC_W-1] ? -ACC_W'(scale_r) : ACC_W'(scale_r);
                idx_next = '0;
                if (kind_reg == REQ_CHOOSE) begin
                    state_next = S_WALK_RD;
                end else begin
                    walk_phase_next = 1'b1;
                    state_next = S_Q_RD;
                end
            end
            S_WALK_RD: state_next = S_WALK_CMP;
            S_WALK_CMP: begin
                idx_next = idx_inc;
                if (target_reg <= ACC_W'(rd_w)) begin
                    res_idx_next = 8'(idx_reg);
                    state_next = S_DONE;
                end else begin
                    target_next = target_reg - ACC_W'(rd_w);
                    if (idx_inc == n_act) begin
                        res_idx_next = 8'(idx_reg);
                        state_next = S_DONE;
                    end else begin
                        state_next = S_WALK_RD;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next = res_idx_reg;
                    m_tuser_next = res_choice_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            idx_reg <= '0;
            total_reg <= RESET_TOTAL;
            bound_reg <= FIX_ONE;
            eiu_reg <= 9'd256;
            initw_reg <= FIX_ONE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            total_reg <= total_next;
            bound_reg <= bound_next;
            eiu_reg <= eiu_next;
            initw_reg <= initw_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        eidx_reg <= eidx_next;
        nw_reg <= nw_next;
        frac_reg <= frac_next;
        delta_reg <= delta_next;
        scale_val_reg <= scale_val_next;
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        target_reg <= target_next;
        sum_reg <= sum_next;
        div_d_reg <= div_d_next;
        rem_reg <= rem_next;
        shreg_reg <= shreg_next;
        quo_reg <= quo_next;
        dcnt_reg <= dcnt_next;
        walk_phase_reg <= walk_phase_next;
        res_idx_reg <= res_idx_next;
        res_choice_reg <= res_choice_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // one request at a time: a transfer in closes the input until its result is out
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in progress");

    // walks only read the table
    a_walk_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK_CMP || state_reg == S_Q_USE || state_reg == S_Q_DIV) |-> !ram_we)
        else $error("table written during a walk");

    // after the raise step a plain choice sees no negative bound
    a_bound_raised: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK && kind_reg == REQ_CHOOSE) |-> !bound_reg[WEIGHT_W-1])
        else $error("bound still negative at choice");

    // a finished result reaches the output once it is free
    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && out_free) |=> (m_tvalid && state_reg == S_IDLE))
        else $error("result not presented");

endmodule

>>> sim/tb_weighted_index_roulette_select_core.sv
// Self-checking testbench for weighted_index_roulette_select_core.
// Predicts every result from its own copy of the weight table; depends on wirs_pkg.
`timescale 1ns / 1ps

module tb_weighted_index_roulette_select_core;
    import wirs_pkg::*;

    localparam longint ONE_Q = 65536;
    localparam longint W_MAX = 64'sd2147483647;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] chosen_index;
        logic       is_choice;
    } pick_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;    // entry_index, new_weight, random_fraction
    logic [2:0]  s_tuser = '0;    // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // chosen_index
    logic        m_tuser;         // is_choice
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    weighted_index_roulette_select_core DUT (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    // predictor state
    logic signed [31:0] wt_table [256];
    longint             wt_total;
    longint             wt_bound;
    int unsigned        n_in_use;
    longint             clear_weight;

    pick_t       pick_queue[$];
    int          err_count = 0;
    int          sent_count = 0;
    int          choice_count = 0;
    bit          no_idle = 0;
    int          ready_stall = 0;
    int          quiet_cycles = 0;

    function automatic longint wrap48(longint v);
        logic signed [47:0] t;
        t = v[47:0];
        return t;
    endfunction

    function automatic void raise_all(int unsigned n, longint delta);
        longint old_w, new_w;
        for (int i = 0; i < n; i++) begin
            old_w = wt_table[i];
            new_w = old_w + delta;
            if (new_w > W_MAX) new_w = W_MAX;
            wt_table[i] = new_w[31:0];
            wt_total = wrap48(wt_total + new_w - old_w);
        end
    endfunction

    // value * frac / 2^32, magnitude truncated
    function automatic longint scale_by_fraction(longint v, longint unsigned frac);
        longint unsigned mag, r;
        mag = (v < 0) ? longint'(-v) : v;
        r = (mag >> 32) * frac + (((mag & 64'hFFFF_FFFF) * frac) >> 32);
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint inverse_share(longint w);
        longint unsigned t, d, q;
        t = (wt_total < 0) ? longint'(-wt_total) : wt_total;
        d = (w < ONE_Q) ? ONE_Q : w;
        q = ((t / d) << 16) + (((t % d) << 16) / d);
        return (wt_total < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic pick_t predict_request(logic [2:0] kind, logic [7:0] idx,
                                              logic signed [31:0] nw,
                                              logic [31:0] frac);
        pick_t  r;
        longint target, sum, q;
        int unsigned n;
        r = '0;
        n = (n_in_use > 256) ? 256 : n_in_use;
        case (kind)
            REQ_SET_WEIGHT: begin
                wt_total = wrap48(wt_total - longint'(wt_table[idx]) + longint'(nw));
                wt_table[idx] = nw;
                if (longint'(nw) < wt_bound) wt_bound = nw;
            end
            REQ_REMOVE: begin
                wt_total = wrap48(wt_total - longint'(wt_table[idx]));
                wt_table[idx] = 0;
                if (wt_bound > 0) wt_bound = 0;
            end
            REQ_CLEAR: begin
                foreach (wt_table[i]) wt_table[i] = clear_weight[31:0];
                wt_total = wrap48(longint'(n) * clear_weight);
                wt_bound = clear_weight;
            end
            REQ_CHOOSE: begin
                r.is_choice = 1'b1;
                if (wt_bound < 0) begin
                    raise_all(n, -wt_bound);
                    wt_bound = 0;
                end
                if (n > 0) begin
                    target = scale_by_fraction(wt_total, frac);
                    r.chosen_index = 8'(n - 1);
                    for (int i = 0; i < n; i++) begin
                        if (target <= longint'(wt_table[i])) begin
                            r.chosen_index = 8'(i);
                            break;
                        end
                        target -= wt_table[i];
                    end
                end
            end
            REQ_INV_CHOOSE: begin
                r.is_choice = 1'b1;
                if (wt_bound < ONE_Q) begin
                    raise_all(n, ONE_Q - wt_bound);
                    wt_bound = ONE_Q;
                end
                if (n > 0) begin
                    sum = 0;
                    for (int i = 0; i < n; i++) sum += inverse_share(wt_table[i]);
                    target = scale_by_fraction(sum, frac);
                    r.chosen_index = 8'(n - 1);
                    for (int i = 0; i < n; i++) begin
                        q = inverse_share(wt_table[i]);
                        if (target <= q) begin
                            r.chosen_index = 8'(i);
                            break;
                        end
                        target -= q;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // result side: random stalls, compare against oldest expectation
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (pick_queue.size() == 0) begin
                $error("unexpected result: chosen_index=%0d is_choice=%0d", m_tdata, m_tuser);
                err_count++;
            end else begin
                pick_t e;
                e = pick_queue.pop_front();
                if (m_tdata !== e.chosen_index) begin
                    $error("chosen_index: expected %0d, got %0d", e.chosen_index, m_tdata);
                    err_count++;
                end
                if (m_tuser !== e.is_choice) begin
                    $error("is_choice: expected %0d, got %0d", e.is_choice, m_tuser);
                    err_count++;
                end
            end
            ready_stall = no_idle ? 0 : $urandom_range(0, 4);
        end
        if (ready_stall > 0) begin
            ready_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(logic [2:0] kind, logic [7:0] idx,
                             logic signed [31:0] nw, logic [31:0] frac);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        pick_queue.push_back(predict_request(kind, idx, nw, frac));
        sent_count++;
        if (kind == REQ_CHOOSE || kind == REQ_INV_CHOOSE) choice_count++;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {frac, nw, idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pick_queue.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic index, logic [31:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (index == REG_ENTRIES_IN_USE) n_in_use = value[8:0];
        else clear_weight = longint'(signed'(value));
    endtask

    function automatic logic signed [31:0] rand_weight();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return $urandom_range(0, 4 * 65536);
        if (sel < 7) return -$signed($urandom_range(0, 2 * 65536));
        if (sel == 7) return $urandom;
        return (sel == 8) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endfunction

    task automatic test_directed;
        // defaults: 256 entries of 1.0
        send_item(REQ_CHOOSE, 8'd0, 32'sd0, 32'h0000_0000);
        send_item(REQ_CHOOSE, 8'd0, 32'sd0, 32'hFFFF_FFFF);
        send_item(REQ_SET_WEIGHT, 8'd0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(REQ_SET_WEIGHT, 8'd255, 32'sh8000_0000, 32'h0);
        send_item(REQ_REMOVE, 8'd255, 32'sd0, 32'h0);
        send_item(REQ_CHOOSE, 8'd0, 32'sd0, 32'h8000_0000);
        send_item(3'd5, 8'hFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(3'd6, 8'd0, 32'sd0, 32'h0);
        send_item(3'd7, 8'hAA, 32'sh5555_5555, 32'hAAAA_AAAA);
        write_reg(REG_ENTRIES_IN_USE, 32'd4);
        write_reg(REG_INITIAL_WEIGHT, 32'h8000_0000);
        send_item(REQ_CLEAR, 8'd0, 32'sd0, 32'h0);
        // most negative weights: each choice raises the entries in use
        send_item(REQ_CHOOSE, 8'd0, 32'sd0, 32'h4000_0000);
        send_item(REQ_INV_CHOOSE, 8'd0, 32'sd0, 32'hC000_0000);
        send_item(REQ_SET_WEIGHT, 8'd2, 32'sd32768, 32'h0);
        send_item(REQ_INV_CHOOSE, 8'd0, 32'sd0, 32'hFFFF_FFFF);
        write_reg(REG_INITIAL_WEIGHT, 32'h7FFF_FFFF);
        write_reg(REG_ENTRIES_IN_USE, 32'd1);
        send_item(REQ_CLEAR, 8'd0, 32'sd0, 32'h0);
        send_item(REQ_INV_CHOOSE, 8'd0, 32'sd0, 32'h1234_5678);
        // entries in use grows over entries left at the maximum weight; the raise saturates
        write_reg(REG_ENTRIES_IN_USE, 32'd3);
        send_item(REQ_SET_WEIGHT, 8'd1, 32'sd100, 32'h0);
        send_item(REQ_INV_CHOOSE, 8'd0, 32'sd0, 32'h9000_0000);
        send_item(REQ_CHOOSE, 8'd0, 32'sd0, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_random_phases;
        int unsigned n;
        logic [2:0]  kind;
        int          sel, count;
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 0) n = 256;
            else if (ph == 1) n = 1;
            else n = $urandom_range(1, 8);
            write_reg(REG_ENTRIES_IN_USE, n);
            case (ph % 4)
                0: write_reg(REG_INITIAL_WEIGHT, 32'h0001_0000);
                1: write_reg(REG_INITIAL_WEIGHT, 32'h8000_0000);
                2: write_reg(REG_INITIAL_WEIGHT, 32'h7FFF_FFFF);
                default: write_reg(REG_INITIAL_WEIGHT, $urandom_range(0, 8 * 65536));
            endcase
            no_idle = (ph % 5 == 3);
            send_item(REQ_CLEAR, 8'($urandom), $urandom, $urandom);
            count = (n == 256) ? 12 : 85;
            for (int k = 0; k < count; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 30) kind = REQ_SET_WEIGHT;
                else if (sel < 40) kind = REQ_REMOVE;
                else if (sel < 44) kind = REQ_CLEAR;
                else if (sel < 72) kind = REQ_CHOOSE;
                else if (sel < 95) kind = REQ_INV_CHOOSE;
                else kind = 3'($urandom_range(5, 7));
                send_item(kind,
                          8'((n == 256 || sel[0]) ? $urandom : $urandom_range(0, n - 1)),
                          rand_weight(), $urandom);
                if (k == 40) drain();   // hold off until everything is back
            end
            no_idle = 0;
        end
        drain();
    endtask

    initial begin
        foreach (wt_table[i]) wt_table[i] = ONE_Q[31:0];
        n_in_use     = 256;
        clear_weight = ONE_Q;
        wt_total     = 256 * ONE_Q;
        wt_bound     = ONE_Q;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_phases();

        repeat (50) @(posedge aclk);
        $display("Sent %0d requests (%0d choices) across 12 table settings,", sent_count,
                 choice_count);
        $display("including extreme weights, saturating raises and unknown kinds.");
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/wirs_pkg.sv
hw/rtl/wirs_ram.sv
hw/rtl/weighted_index_roulette_select_core.sv
sim/tb_weighted_index_roulette_select_core.sv
